// File: rtl/mfv_pkg.sv
// Shared constants, state encoding and control structs for the mode finder.
`timescale 1ns / 1ps
`default_nettype none

package mfv_pkg;

   localparam int MAX_ELEMS_DEFAULT = 64;
   localparam int VALUE_W           = 32;
   localparam int MODE_COUNT_W      = 7;

   localparam logic [MODE_COUNT_W-1:0] MODE_COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LATCH,
      ST_SCAN,
      ST_ROW_END,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // store the accepted request
      logic begin_set; // closing request: reset candidate pointer and best
      logic read_i;    // fetch candidate element i
      logic latch;     // capture candidate, fetch element 0
      logic scan;      // compare one element, fetch the next
      logic row_end;   // fold the finished row into the best so far
      logic emit;      // present result, clear the set
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_j;    // every element of the row has been fetched
      logic last_i;    // current candidate is the final stored element
   } status_type;

endpackage

`default_nettype wire

// File: rtl/mfv_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mfv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/mfv_ctrl.sv
// Sequencer for loading a set and scanning it pairwise for the mode.
`timescale 1ns / 1ps
`default_nettype none

module mfv_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_last,
   input  wire mfv_pkg::status_type status,
   output mfv_pkg::cmd_type        cmd,
   output logic                    busy
);

   import mfv_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_last) begin
               state_in = ST_RD_I;
            end
         end
         ST_RD_I:  state_in = ST_LATCH;
         ST_LATCH: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.last_j) begin
               state_in = ST_ROW_END;
            end
         end
         ST_ROW_END: begin
            state_in = status.last_i ? ST_DONE : ST_RD_I;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.load      = start;
            cmd.begin_set = start & req_last;
         end
         ST_RD_I:    cmd.read_i  = 1'b1;
         ST_LATCH:   cmd.latch   = 1'b1;
         ST_SCAN:    cmd.scan    = 1'b1;
         ST_ROW_END: cmd.row_end = 1'b1;
         ST_DONE:    cmd.emit    = 1'b1;
         default:    busy        = 1'b1;
      endcase
   end

   // result strobe lasts one cycle
   a_emit_single : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("result strobe held for more than one cycle");

   // leaving busy only happens right after a result
   a_busy_drop : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(cmd.emit))
      else $error("busy dropped without a result");

   // no request is taken while a scan runs
   a_no_load_busy : assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("request loaded while busy");

endmodule

`default_nettype wire

// File: rtl/mfv_datapath.sv
// Element store, scan counters, match counter and best-so-far registers.
`timescale 1ns / 1ps
`default_nettype none

module mfv_datapath #(
   parameter int MAX_ELEMS = mfv_pkg::MAX_ELEMS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mfv_pkg::cmd_type                      cmd,
   output mfv_pkg::status_type                        status,
   input  wire logic signed [mfv_pkg::VALUE_W-1:0]    req_value,
   output logic signed      [mfv_pkg::VALUE_W-1:0]    rsp_mode_value,
   output logic             [mfv_pkg::MODE_COUNT_W-1:0] rsp_mode_count,
   output logic                                       rsp_overflow
);

   import mfv_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMS);
   localparam int CNT_W = $clog2(MAX_ELEMS + 1);

   logic [CNT_W-1:0]   n_ff, n_in;
   logic               dropped_ff, dropped_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   hits_ff, hits_in;
   logic [CNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [VALUE_W-1:0] best_val_ff, best_val_in;
   logic [VALUE_W-1:0] cand_ff, cand_in;

   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               has_room;
   logic               match;

   assign has_room = n_ff < CNT_W'(MAX_ELEMS);
   assign wr_en    = cmd.load & has_room;
   assign rd_addr  = cmd.read_i ? i_ff : j_ff[IDX_W-1:0];
   assign match    = (rd_data == cand_ff);

   mfv_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (n_ff[IDX_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.last_j = (j_ff == n_ff);
   assign status.last_i = ((CNT_W'(i_ff) + CNT_W'(1)) == n_ff);

   always_comb begin
      n_in        = n_ff;
      dropped_in  = dropped_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      hits_in     = hits_ff;
      best_cnt_in = best_cnt_ff;
      best_val_in = best_val_ff;
      cand_in     = cand_ff;

      if (cmd.load) begin
         if (has_room) begin
            n_in = n_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.begin_set) begin
         i_in        = '0;
         best_cnt_in = '0;
         best_val_in = '0;
      end
      if (cmd.read_i) begin
         j_in = '0;
      end
      if (cmd.latch) begin
         cand_in = rd_data;
         hits_in = '0;
         j_in    = j_ff + CNT_W'(1);
      end
      if (cmd.scan) begin
         hits_in = hits_ff + CNT_W'(match);
         if (!status.last_j) begin
            j_in = j_ff + CNT_W'(1);
         end
      end
      if (cmd.row_end) begin
         // strict compare keeps the earliest value on a tie
         if (hits_ff > best_cnt_ff) begin
            best_cnt_in = hits_ff;
            best_val_in = cand_ff;
         end
         if (!status.last_i) begin
            i_in = i_ff + IDX_W'(1);
         end
      end
      if (cmd.emit) begin
         n_in       = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff       <= '0;
         dropped_ff <= 1'b0;
      end else begin
         n_ff       <= n_in;
         dropped_ff <= dropped_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      hits_ff     <= hits_in;
      best_cnt_ff <= best_cnt_in;
      best_val_ff <= best_val_in;
      cand_ff     <= cand_in;
   end

   assign rsp_mode_value = best_val_ff;
   assign rsp_overflow   = dropped_ff;

   generate
      if (CNT_W > MODE_COUNT_W) begin : g_sat
         assign rsp_mode_count = (best_cnt_ff > CNT_W'(MODE_COUNT_MAX)) ?
                                 MODE_COUNT_MAX : best_cnt_ff[MODE_COUNT_W-1:0];
      end else begin : g_ext
         assign rsp_mode_count = MODE_COUNT_W'(best_cnt_ff);
      end
   endgenerate

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_ELEMS))
      else $error("fill count beyond store depth");

   a_best_sane : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (best_cnt_ff != '0) && (best_cnt_ff <= n_ff))
      else $error("mode count out of range at result");

   a_drop_flag : assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !has_room) |=> dropped_ff)
      else $error("dropped request not flagged");

endmodule

`default_nettype wire

// File: rtl/most_frequent_value_core.sv
// Top level: mode of a loaded set of signed values, earliest value on a tie.
// A non-closing request is stored while busy stays low, one request a cycle.
// A closing request with n stored elements keeps busy high until the result;
// the result strobe is the last busy cycle. Each of the n rows takes a candidate
// fetch, a latch, a compare per element and a fold, all through the store's single read port.
// Reset clears the fill count and drop flag; store contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module most_frequent_value_core #(
   parameter int MAX_ELEMS = mfv_pkg::MAX_ELEMS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel: taken when start is high and busy low
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [mfv_pkg::VALUE_W-1:0]    req_value,
   input  wire logic                                  req_last,
   // result channel: one-cycle strobe, cannot be held off
   output logic                                       rsp_valid,
   output logic signed      [mfv_pkg::VALUE_W-1:0]    rsp_mode_value,
   output logic             [mfv_pkg::MODE_COUNT_W-1:0] rsp_mode_count,
   output logic                                       rsp_overflow
);

   import mfv_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: idles taking requests, then walks candidate rows after the
   // closing request and raises the strobe once every row is folded in.
   mfv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Datapath: store, pointers, match counter and the best so far.
   // Elements beyond the store depth are dropped and flagged.
   mfv_datapath #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .rsp_mode_value (rsp_mode_value),
      .rsp_mode_count (rsp_mode_count),
      .rsp_overflow   (rsp_overflow)
   );

   // result registers are stable while the strobe is up; the set clears after
   assign rsp_valid = cmd.emit;

   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a scan");

   a_rsp_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode_count != '0))
      else $error("result with zero count");

   a_idle_after : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after result");

endmodule

`default_nettype wire
